// ===== rtl/tbss_pkg.sv =====
package tbss_pkg;

    localparam int unsigned NUM_SLOTS = 2;
    localparam int unsigned STORED_FRAGS = 3;
    localparam int unsigned FRAG_W = 32;
    localparam int unsigned IN_DATA_W = 56;
    localparam int unsigned OUT_DATA_W = 152;

    typedef enum logic [3:0] {
        SYNC_NONE     = 4'd0,
        SYNC_BS_VOICE = 4'd1,
        SYNC_BS_DATA  = 4'd2,
        SYNC_MS_VOICE = 4'd3,
        SYNC_MS_DATA  = 4'd4,
        SYNC_TS1_VOICE = 4'd5,
        SYNC_TS1_DATA = 4'd6,
        SYNC_TS2_VOICE = 4'd7,
        SYNC_TS2_DATA = 4'd8
    } sync_kind_t;

    typedef enum logic [1:0] {
        GRADE_BAD     = 2'd0,
        GRADE_OK      = 2'd1,
        GRADE_NEUTRAL = 2'd2
    } grade_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_IDLE    = 3'd1,
        ACT_VOICE   = 3'd2,
        ACT_CONTROL = 3'd3,
        ACT_DATA    = 3'd4
    } activity_t;

    typedef enum logic [1:0] {
        LCSS_SINGLE = 2'd0,
        LCSS_FIRST  = 2'd1,
        LCSS_LAST   = 2'd2,
        LCSS_CONT   = 2'd3
    } lcss_t;

    localparam logic [3:0] DT_VOICE_LC  = 4'd1;
    localparam logic [3:0] DT_IDLE      = 4'd2;
    localparam logic [3:0] DT_CSBK      = 4'd3;
    localparam logic [3:0] DT_IDLE_ALT  = 4'd9;

    localparam logic [2:0] POS_NONE = 3'd7;
    localparam logic [2:0] POS_LAST = 3'd5;
    localparam logic [1:0] EMB_RUN_MAX = 2'd3;
    localparam logic [4:0] COLOR_UNKNOWN = 5'h1F;

endpackage

// ===== rtl/tdma_burst_slot_sequencer.sv =====
// channel  | dir | tdata fields (lsb up)                                  | tuser
// s_axis   | in  | base_station, tact_ok, tact_slot_bit, slot_type_ok,     | sync_kind
//          |     | slot_type_cc, data_type, emb_ok, emb_cc, lcss,          |
//          |     | fragment, clear_proven (52 bits, zero-padded to 56)     |
// m_axis   | out | slot, grade, play_voice, voice_position, color_code,    | -
//          |     | activity, simplex_mode, lc_ready, lc_upper, lc_lower    |
//          |     | (145 bits, zero-padded to 152)                          |
// one burst per cycle unless m_axis stalls; state, result computed in the accept cycle
// the result appears in the output register in the cycle after acceptance
// s_axis_tready is high whenever the output register is empty or being drained
// rst_n clears all slot tracking state; the fragment words need no reset
module tdma_burst_slot_sequencer
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // base_station, tact_ok, tact_slot_bit, slot_type_ok, slot_type_cc, data_type,
    // emb_ok, emb_cc, lcss, fragment, clear_proven
    input  logic [tbss_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // sync_kind
    input  logic [3:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // slot, grade, play_voice, voice_position, color_code, activity, simplex_mode,
    // lc_ready, lc_upper, lc_lower
    output logic [tbss_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    logic [3:0]  kind;
    logic        bs;
    logic        tact_ok;
    logic        tc;
    logic        st_ok;
    logic [3:0]  st_cc;
    logic [3:0]  dt;
    logic        emb_ok;
    logic [3:0]  emb_cc;
    logic [1:0]  lcss;
    logic [31:0] frag;
    logic        clr;

    assign kind    = s_axis_tuser;
    assign bs      = s_axis_tdata[0];
    assign tact_ok = s_axis_tdata[1];
    assign tc      = s_axis_tdata[2];
    assign st_ok   = s_axis_tdata[3];
    assign st_cc   = s_axis_tdata[7:4];
    assign dt      = s_axis_tdata[11:8];
    assign emb_ok  = s_axis_tdata[12];
    assign emb_cc  = s_axis_tdata[16:13];
    assign lcss    = s_axis_tdata[18:17];
    assign frag    = s_axis_tdata[50:19];
    assign clr     = s_axis_tdata[51];

    logic       prev_slot_reg, prev_slot_next;
    logic       direct_reg, direct_next;
    logic       simplex_reg, simplex_next;
    logic       proven_reg, proven_next;
    logic       disagree_reg, disagree_next;
    logic [2:0] pos_reg [tbss_pkg::NUM_SLOTS];
    logic [2:0] pos_next [tbss_pkg::NUM_SLOTS];
    logic [1:0] bad_run_reg [tbss_pkg::NUM_SLOTS];
    logic [1:0] bad_run_next [tbss_pkg::NUM_SLOTS];
    logic [1:0] frag_cnt_reg [tbss_pkg::NUM_SLOTS];
    logic [1:0] frag_cnt_next [tbss_pkg::NUM_SLOTS];
    logic [4:0] color_reg [tbss_pkg::NUM_SLOTS];
    logic [4:0] color_next [tbss_pkg::NUM_SLOTS];
    logic [2:0] act_reg [tbss_pkg::NUM_SLOTS];
    logic [2:0] act_next [tbss_pkg::NUM_SLOTS];
    logic [tbss_pkg::FRAG_W-1:0] frag_reg
        [tbss_pkg::NUM_SLOTS][tbss_pkg::STORED_FRAGS];

    logic        out_valid_reg;
    logic [tbss_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic        accept;
    logic        slot;
    logic [1:0]  grade;
    logic        play;
    logic [2:0]  vpos;
    logic        ready;
    logic        frag_we;
    logic [1:0]  frag_idx;
    logic [63:0] upper;
    logic [63:0] lower;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    always_comb
    begin
        logic       is_data;
        logic       is_voice;
        logic [2:0] p;
        logic [1:0] n;
        logic [1:0] run;

        is_data  = (kind == tbss_pkg::SYNC_BS_DATA) || (kind == tbss_pkg::SYNC_MS_DATA)
                || (kind == tbss_pkg::SYNC_TS1_DATA) || (kind == tbss_pkg::SYNC_TS2_DATA);
        is_voice = (kind == tbss_pkg::SYNC_BS_VOICE) || (kind == tbss_pkg::SYNC_MS_VOICE)
                || (kind == tbss_pkg::SYNC_TS1_VOICE) || (kind == tbss_pkg::SYNC_TS2_VOICE);

        proven_next   = clr ? 1'b0 : proven_reg;
        disagree_next = disagree_reg;
        pos_next      = pos_reg;
        bad_run_next  = bad_run_reg;
        frag_cnt_next = frag_cnt_reg;
        color_next    = color_reg;
        act_next      = act_reg;
        grade    = tbss_pkg::GRADE_BAD;
        play     = 1'b0;
        vpos     = 3'd0;
        ready    = 1'b0;
        frag_we  = 1'b0;
        frag_idx = 2'd0;
        p        = 3'd0;
        n        = 2'd0;
        run      = 2'd0;

        if (kind >= tbss_pkg::SYNC_TS1_VOICE && kind <= tbss_pkg::SYNC_TS2_DATA)
            direct_next = 1'b1;
        else if (kind != tbss_pkg::SYNC_NONE)
            direct_next = 1'b0;
        else
            direct_next = direct_reg;

        if (bs || direct_next)
            simplex_next = 1'b0;
        else if (kind == tbss_pkg::SYNC_MS_VOICE || kind == tbss_pkg::SYNC_MS_DATA)
            simplex_next = 1'b1;
        else
            simplex_next = simplex_reg;

        // slot assignment with tact re-phase after two disagreements
        if (bs)
        begin
            slot = !prev_slot_reg;
            if (tact_ok)
            begin
                if (tc == slot)
                    disagree_next = 1'b0;
                else if (disagree_reg)
                begin
                    slot = tc;
                    disagree_next = 1'b0;
                end
                else
                    disagree_next = 1'b1;
            end
        end
        else if (kind == tbss_pkg::SYNC_TS1_VOICE || kind == tbss_pkg::SYNC_TS1_DATA)
            slot = 1'b0;
        else if (kind == tbss_pkg::SYNC_TS2_VOICE || kind == tbss_pkg::SYNC_TS2_DATA)
            slot = 1'b1;
        else if (direct_next && kind == tbss_pkg::SYNC_NONE)
            slot = !prev_slot_reg;
        else
            slot = 1'b0;
        prev_slot_next = slot;

        if (is_data)
        begin
            if (st_ok)
            begin
                color_next[slot] = {1'b0, st_cc};
                pos_next[slot] = tbss_pkg::POS_NONE;
                if (dt == tbss_pkg::DT_VOICE_LC)
                    act_next[slot] = tbss_pkg::ACT_VOICE;
                else if (dt == tbss_pkg::DT_IDLE || dt == tbss_pkg::DT_IDLE_ALT)
                    act_next[slot] = tbss_pkg::ACT_IDLE;
                else if (dt == tbss_pkg::DT_CSBK)
                    act_next[slot] = tbss_pkg::ACT_CONTROL;
                else
                    act_next[slot] = tbss_pkg::ACT_DATA;
                grade = tbss_pkg::GRADE_OK;
            end
        end
        else if (is_voice)
        begin
            pos_next[slot] = 3'd0;
            frag_cnt_next[slot] = 2'd0;
            bad_run_next[slot] = 2'd0;
            grade = tbss_pkg::GRADE_NEUTRAL;
            play = proven_next;
        end
        else if (pos_reg[slot] != tbss_pkg::POS_NONE)
        begin
            p = pos_reg[slot] + 3'd1;
            if (pos_reg[slot] >= tbss_pkg::POS_LAST)
                pos_next[slot] = tbss_pkg::POS_NONE;
            else
            begin
                pos_next[slot] = p;
                if (proven_next)
                begin
                    play = 1'b1;
                    vpos = p;
                end
                if (!emb_ok)
                begin
                    frag_cnt_next[slot] = 2'd0;
                    run = bad_run_reg[slot];
                    if (run != tbss_pkg::EMB_RUN_MAX)
                        run = run + 2'd1;
                    bad_run_next[slot] = run;
                    if (run == tbss_pkg::EMB_RUN_MAX)
                        pos_next[slot] = tbss_pkg::POS_NONE;
                end
                else
                begin
                    n = frag_cnt_reg[slot];
                    bad_run_next[slot] = 2'd0;
                    color_next[slot] = {1'b0, emb_cc};
                    act_next[slot] = tbss_pkg::ACT_VOICE;
                    if (lcss == tbss_pkg::LCSS_FIRST)
                    begin
                        frag_we = 1'b1;
                        frag_idx = 2'd0;
                        frag_cnt_next[slot] = 2'd1;
                    end
                    else if (lcss == tbss_pkg::LCSS_CONT && (n == 2'd1 || n == 2'd2))
                    begin
                        frag_we = 1'b1;
                        frag_idx = n;
                        frag_cnt_next[slot] = n + 2'd1;
                    end
                    else if (lcss == tbss_pkg::LCSS_LAST && n == 2'd3)
                    begin
                        frag_cnt_next[slot] = 2'd0;
                        ready = 1'b1;
                    end
                    else if (lcss != tbss_pkg::LCSS_SINGLE)
                        frag_cnt_next[slot] = 2'd0;
                    grade = tbss_pkg::GRADE_OK;
                end
            end
        end

        if (grade == tbss_pkg::GRADE_OK)
            proven_next = 1'b1;
    end

    assign upper = ready ? {frag_reg[slot][0], frag_reg[slot][1]} : 64'd0;
    assign lower = ready ? {frag_reg[slot][2], frag} : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_slot_reg <= 1'b0;
            direct_reg    <= 1'b0;
            simplex_reg   <= 1'b0;
            proven_reg    <= 1'b0;
            disagree_reg  <= 1'b0;
            for (int i = 0; i < tbss_pkg::NUM_SLOTS; i++)
            begin
                pos_reg[i]      <= tbss_pkg::POS_NONE;
                bad_run_reg[i]  <= 2'd0;
                frag_cnt_reg[i] <= 2'd0;
                color_reg[i]    <= tbss_pkg::COLOR_UNKNOWN;
                act_reg[i]      <= tbss_pkg::ACT_NONE;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                prev_slot_reg <= prev_slot_next;
                direct_reg    <= direct_next;
                simplex_reg   <= simplex_next;
                proven_reg    <= proven_next;
                disagree_reg  <= disagree_next;
                pos_reg       <= pos_next;
                bad_run_reg   <= bad_run_next;
                frag_cnt_reg  <= frag_cnt_next;
                color_reg     <= color_next;
                act_reg       <= act_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (frag_we)
                frag_reg[slot][frag_idx] <= frag;
            out_data_reg <= {7'd0, lower, upper, ready, simplex_next,
                             act_next[slot], color_next[slot], vpos, play, grade, slot};
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic [3:0]  kind;
        logic        bs;
        logic        tact_ok;
        logic        tc;
        logic        st_ok;
        logic [3:0]  st_cc;
        logic [3:0]  dt;
        logic        emb_ok;
        logic [3:0]  emb_cc;
        logic [1:0]  lcss;
        logic [31:0] frag;
        logic        clr;
        bit          pause_before;
    } burst_t;

    typedef struct {
        logic                 slot;
        tbss_pkg::grade_t     grade;
        logic                 play;
        logic [2:0]           vpos;
        logic [4:0]           color;
        tbss_pkg::activity_t  activity;
        logic                 simplex;
        logic                 ready;
        logic [63:0]          upper;
        logic [63:0]          lower;
    } burst_result_t;

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [tbss_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [3:0]                      s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [tbss_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    tdma_burst_slot_sequencer uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    burst_t        burst_queue[$];
    burst_result_t expected_results[$];
    burst_t        on_bus;
    int            mismatches = 0;
    int            results_seen = 0;
    int            bursts_accepted = 0;
    int            tx_gap = 0;
    int            rx_gap = 0;
    bit            rx_hold = 1'b0;
    bit            calm = 1'b0;
    bit            gen_slot = 1'b0;

    // tracking state of the sequencer
    logic                 prev_slot;
    logic                 direct_mode;
    logic                 simplex_on;
    logic                 voice_proven;
    logic                 tact_mismatch;
    logic [2:0]           sf_pos[2];
    logic [1:0]           emb_fail_run[2];
    logic [1:0]           frag_cnt[2];
    logic [31:0]          frag_mem[8];
    logic [4:0]           cc_of_slot[2];
    tbss_pkg::activity_t  act_of_slot[2];

    function automatic burst_result_t sequence_burst(input burst_t b);
        burst_result_t r;
        logic          s;
        logic [2:0]    p;
        logic [1:0]    n;
        logic [2:0]    base;
        r.grade = tbss_pkg::GRADE_BAD;
        r.play = 1'b0;
        r.vpos = 3'd0;
        r.ready = 1'b0;
        r.upper = '0;
        r.lower = '0;
        if (b.clr)
            voice_proven = 1'b0;
        if (b.kind >= tbss_pkg::SYNC_TS1_VOICE && b.kind <= tbss_pkg::SYNC_TS2_DATA)
            direct_mode = 1'b1;
        else if (b.kind != tbss_pkg::SYNC_NONE)
            direct_mode = 1'b0;
        if (b.bs || direct_mode)
            simplex_on = 1'b0;
        else if (b.kind == tbss_pkg::SYNC_MS_VOICE || b.kind == tbss_pkg::SYNC_MS_DATA)
            simplex_on = 1'b1;
        if (b.bs)
        begin
            s = ~prev_slot;
            if (b.tact_ok)
            begin
                if (b.tc == s)
                    tact_mismatch = 1'b0;
                else if (tact_mismatch)
                begin
                    s = b.tc;
                    tact_mismatch = 1'b0;
                end
                else
                    tact_mismatch = 1'b1;
            end
        end
        else if (b.kind == tbss_pkg::SYNC_TS1_VOICE || b.kind == tbss_pkg::SYNC_TS1_DATA)
            s = 1'b0;
        else if (b.kind == tbss_pkg::SYNC_TS2_VOICE || b.kind == tbss_pkg::SYNC_TS2_DATA)
            s = 1'b1;
        else if (direct_mode && b.kind == tbss_pkg::SYNC_NONE)
            s = ~prev_slot;
        else
            s = 1'b0;
        prev_slot = s;

        if (b.kind == tbss_pkg::SYNC_BS_DATA || b.kind == tbss_pkg::SYNC_MS_DATA ||
            b.kind == tbss_pkg::SYNC_TS1_DATA || b.kind == tbss_pkg::SYNC_TS2_DATA)
        begin
            if (b.st_ok)
            begin
                cc_of_slot[s] = {1'b0, b.st_cc};
                sf_pos[s] = tbss_pkg::POS_NONE;
                if (b.dt == tbss_pkg::DT_VOICE_LC)
                    act_of_slot[s] = tbss_pkg::ACT_VOICE;
                else if (b.dt == tbss_pkg::DT_IDLE || b.dt == tbss_pkg::DT_IDLE_ALT)
                    act_of_slot[s] = tbss_pkg::ACT_IDLE;
                else if (b.dt == tbss_pkg::DT_CSBK)
                    act_of_slot[s] = tbss_pkg::ACT_CONTROL;
                else
                    act_of_slot[s] = tbss_pkg::ACT_DATA;
                r.grade = tbss_pkg::GRADE_OK;
            end
        end
        else if (b.kind == tbss_pkg::SYNC_BS_VOICE || b.kind == tbss_pkg::SYNC_MS_VOICE ||
                 b.kind == tbss_pkg::SYNC_TS1_VOICE || b.kind == tbss_pkg::SYNC_TS2_VOICE)
        begin
            sf_pos[s] = 3'd0;
            frag_cnt[s] = 2'd0;
            emb_fail_run[s] = 2'd0;
            r.grade = tbss_pkg::GRADE_NEUTRAL;
            if (voice_proven)
                r.play = 1'b1;
        end
        else if (sf_pos[s] != tbss_pkg::POS_NONE)
        begin
            p = sf_pos[s] + 3'd1;
            if (p > tbss_pkg::POS_LAST)
                sf_pos[s] = tbss_pkg::POS_NONE;
            else
            begin
                sf_pos[s] = p;
                if (voice_proven)
                begin
                    r.play = 1'b1;
                    r.vpos = p;
                end
                if (!b.emb_ok)
                begin
                    frag_cnt[s] = 2'd0;
                    if (emb_fail_run[s] < tbss_pkg::EMB_RUN_MAX)
                        emb_fail_run[s] = emb_fail_run[s] + 2'd1;
                    if (emb_fail_run[s] >= tbss_pkg::EMB_RUN_MAX)
                        sf_pos[s] = tbss_pkg::POS_NONE;
                end
                else
                begin
                    n = frag_cnt[s];
                    base = {s, 2'b00};
                    emb_fail_run[s] = 2'd0;
                    cc_of_slot[s] = {1'b0, b.emb_cc};
                    act_of_slot[s] = tbss_pkg::ACT_VOICE;
                    if (b.lcss == tbss_pkg::LCSS_FIRST)
                    begin
                        frag_mem[base] = b.frag;
                        frag_cnt[s] = 2'd1;
                    end
                    else if (b.lcss == tbss_pkg::LCSS_CONT && n >= 2'd1 && n <= 2'd2)
                    begin
                        frag_mem[base + {1'b0, n}] = b.frag;
                        frag_cnt[s] = n + 2'd1;
                    end
                    else if (b.lcss == tbss_pkg::LCSS_LAST && n == 2'd3)
                    begin
                        frag_mem[base + 3'd3] = b.frag;
                        frag_cnt[s] = 2'd0;
                        r.ready = 1'b1;
                        r.upper = {frag_mem[base], frag_mem[base + 3'd1]};
                        r.lower = {frag_mem[base + 3'd2], frag_mem[base + 3'd3]};
                    end
                    else if (b.lcss != tbss_pkg::LCSS_SINGLE)
                        frag_cnt[s] = 2'd0;
                    r.grade = tbss_pkg::GRADE_OK;
                end
            end
        end

        if (r.grade == tbss_pkg::GRADE_OK)
            voice_proven = 1'b1;
        r.slot = s;
        r.color = cc_of_slot[s];
        r.activity = act_of_slot[s];
        r.simplex = simplex_on;
        return r;
    endfunction

    function automatic burst_t noise_burst();
        burst_t b;
        b.kind = 4'($urandom_range(0, 15));
        b.bs = 1'($urandom);
        b.tact_ok = 1'($urandom);
        b.tc = 1'($urandom);
        b.st_ok = 1'($urandom);
        b.st_cc = 4'($urandom);
        b.dt = 4'($urandom);
        b.emb_ok = 1'($urandom);
        b.emb_cc = 4'($urandom);
        b.lcss = 2'($urandom);
        b.frag = $urandom;
        b.clr = ($urandom_range(0, 9) == 0);
        b.pause_before = 1'b0;
        return b;
    endfunction

    function automatic burst_t mk(input logic [3:0] kind, input logic bs, input logic tact_ok,
                                  input logic tc, input logic emb_ok, input logic [1:0] lcss,
                                  input logic [31:0] frag);
        burst_t b;
        b = noise_burst();
        b.kind = kind;
        b.bs = bs;
        b.tact_ok = tact_ok;
        b.tc = tc;
        b.emb_ok = emb_ok;
        b.lcss = lcss;
        b.frag = frag;
        b.clr = 1'b0;
        return b;
    endfunction

    function automatic burst_t mk_data(input logic [3:0] kind, input logic bs,
                                       input logic st_ok, input logic [3:0] cc,
                                       input logic [3:0] dt);
        burst_t b;
        b = mk(kind, bs, 1'b0, 1'b0, 1'($urandom), 2'($urandom), $urandom);
        b.st_ok = st_ok;
        b.st_cc = cc;
        b.dt = dt;
        return b;
    endfunction

    // mode 0 base station, 1 direct mode, 2 ms simplex
    task automatic gen_superframe(input int mode, input int bad_pct);
        burst_t     b;
        int         len;
        int         nslots;
        logic [3:0] kind;
        logic [1:0] lc;
        len = ($urandom_range(0, 5) == 0) ? 8 : 6;
        nslots = (mode == 2) ? 1 : 2;
        for (int pos = 0; pos < len; pos++)
        begin
            for (int sl = 0; sl < nslots; sl++)
            begin
                if (pos != 0)
                    kind = tbss_pkg::SYNC_NONE;
                else if (mode == 0)
                    kind = tbss_pkg::SYNC_BS_VOICE;
                else if (mode == 1)
                    kind = (sl == 0) ? tbss_pkg::SYNC_TS1_VOICE : tbss_pkg::SYNC_TS2_VOICE;
                else
                    kind = tbss_pkg::SYNC_MS_VOICE;
                case (pos)
                    1: lc = tbss_pkg::LCSS_FIRST;
                    2, 3: lc = tbss_pkg::LCSS_CONT;
                    4: lc = tbss_pkg::LCSS_LAST;
                    default: lc = tbss_pkg::LCSS_SINGLE;
                endcase
                if ($urandom_range(0, 9) == 0)
                    lc = 2'($urandom);
                b = mk(kind, mode == 0, 1'b0, 1'b0, $urandom_range(1, 100) > bad_pct,
                       lc, $urandom);
                if (mode == 0)
                begin
                    gen_slot = ~gen_slot;
                    b.tact_ok = ($urandom_range(0, 7) != 0);
                    b.tc = gen_slot ^ ($urandom_range(0, 9) == 0);
                end
                b.clr = ($urandom_range(0, 29) == 0);
                burst_queue.push_back(b);
            end
        end
    endtask

    task automatic gen_data_run();
        burst_t     b;
        logic [3:0] kind;
        int         cnt;
        cnt = $urandom_range(1, 4);
        for (int i = 0; i < cnt; i++)
        begin
            case ($urandom_range(0, 3))
                0: kind = tbss_pkg::SYNC_BS_DATA;
                1: kind = tbss_pkg::SYNC_MS_DATA;
                2: kind = tbss_pkg::SYNC_TS1_DATA;
                default: kind = tbss_pkg::SYNC_TS2_DATA;
            endcase
            b = mk_data(kind, 1'($urandom), $urandom_range(0, 7) != 0, 4'($urandom),
                        4'($urandom));
            b.tact_ok = 1'($urandom);
            b.tc = 1'($urandom);
            b.clr = ($urandom_range(0, 9) == 0);
            burst_queue.push_back(b);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rx_hold <= 1'b0;
        while (bursts_accepted < 300)
            @(posedge clk);
        rx_hold <= 1'b1;
        repeat (250) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(sequence_burst(on_bus));
                bursts_accepted++;
            end
            calm <= (burst_queue.size() < 120);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap <= tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (burst_queue.size() == 0)
                    s_axis_tvalid <= 1'b0;
                else if (burst_queue[0].pause_before && expected_results.size() != 0)
                    s_axis_tvalid <= 1'b0;
                else if (!calm && $urandom_range(0, 7) == 0)
                begin
                    tx_gap <= $urandom_range(0, 13);
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    on_bus = burst_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= on_bus.kind;
                    s_axis_tdata <= {4'b0, on_bus.clr, on_bus.frag, on_bus.lcss,
                                     on_bus.emb_cc, on_bus.emb_ok, on_bus.dt, on_bus.st_cc,
                                     on_bus.st_ok, on_bus.tc, on_bus.tact_ok, on_bus.bs};
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        burst_result_t want;
        burst_result_t got;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                got.slot = m_axis_tdata[0];
                got.grade = tbss_pkg::grade_t'(m_axis_tdata[2:1]);
                got.play = m_axis_tdata[3];
                got.vpos = m_axis_tdata[6:4];
                got.color = m_axis_tdata[11:7];
                got.activity = tbss_pkg::activity_t'(m_axis_tdata[14:12]);
                got.simplex = m_axis_tdata[15];
                got.ready = m_axis_tdata[16];
                got.upper = m_axis_tdata[80:17];
                got.lower = m_axis_tdata[144:81];
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing expected", results_seen);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.slot !== want.slot || got.grade !== want.grade ||
                        got.play !== want.play || got.vpos !== want.vpos ||
                        got.color !== want.color || got.activity !== want.activity ||
                        got.simplex !== want.simplex || got.ready !== want.ready ||
                        got.upper !== want.upper || got.lower !== want.lower)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch on result %0d (expected/actual): slot %b/%b grade %0d/%0d play %b/%b pos %0d/%0d",
                                     results_seen, want.slot, got.slot, want.grade, got.grade,
                                     want.play, got.play, want.vpos, got.vpos);
                            $display("  cc %0d/%0d act %0d/%0d simplex %b/%b ready %b/%b",
                                     $signed(want.color), $signed(got.color),
                                     want.activity, got.activity, want.simplex, got.simplex,
                                     want.ready, got.ready);
                            $display("  upper %h/%h lower %h/%h",
                                     want.upper, got.upper, want.lower, got.lower);
                        end
                    end
                end
            end
            if (rx_hold)
                m_axis_tready <= 1'b0;
            else if (rx_gap > 0)
            begin
                rx_gap <= rx_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                rx_gap <= $urandom_range(0, 13);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        burst_t b;
        prev_slot = 1'b0;
        direct_mode = 1'b0;
        simplex_on = 1'b0;
        voice_proven = 1'b0;
        tact_mismatch = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            sf_pos[i] = tbss_pkg::POS_NONE;
            emb_fail_run[i] = 2'd0;
            frag_cnt[i] = 2'd0;
            cc_of_slot[i] = tbss_pkg::COLOR_UNKNOWN;
            act_of_slot[i] = tbss_pkg::ACT_NONE;
        end
        for (int i = 0; i < 8; i++)
            frag_mem[i] = '0;

        // tact from reset: disagree twice to rephase, agree, bad tact, disagree, agree
        burst_queue.push_back(mk(tbss_pkg::SYNC_BS_VOICE, 1'b1, 1'b1, 1'b0, 1'b1,
                                 tbss_pkg::LCSS_SINGLE, 32'h0000_0000));
        burst_queue.push_back(mk(tbss_pkg::SYNC_NONE, 1'b1, 1'b1, 1'b1, 1'b1,
                                 tbss_pkg::LCSS_SINGLE, 32'hFFFF_FFFF));
        burst_queue.push_back(mk(tbss_pkg::SYNC_BS_VOICE, 1'b1, 1'b1, 1'b0, 1'b1,
                                 tbss_pkg::LCSS_SINGLE, 32'h0000_0000));
        burst_queue.push_back(mk(tbss_pkg::SYNC_NONE, 1'b1, 1'b0, 1'b1, 1'b1,
                                 tbss_pkg::LCSS_SINGLE, 32'hFFFF_FFFF));
        burst_queue.push_back(mk(tbss_pkg::SYNC_BS_VOICE, 1'b1, 1'b1, 1'b1, 1'b1,
                                 tbss_pkg::LCSS_SINGLE, 32'h0000_0000));
        burst_queue.push_back(mk(tbss_pkg::SYNC_NONE, 1'b1, 1'b1, 1'b1, 1'b1,
                                 tbss_pkg::LCSS_SINGLE, 32'hFFFF_FFFF));
        // data bursts, every data type class and a failed slot type
        burst_queue.push_back(mk_data(tbss_pkg::SYNC_BS_DATA, 1'b1, 1'b0, 4'hF, 4'h0));
        burst_queue.push_back(mk_data(tbss_pkg::SYNC_BS_DATA, 1'b1, 1'b1, 4'hF,
                                      tbss_pkg::DT_VOICE_LC));
        burst_queue.push_back(mk_data(tbss_pkg::SYNC_MS_DATA, 1'b0, 1'b1, 4'h0,
                                      tbss_pkg::DT_IDLE));
        burst_queue.push_back(mk_data(tbss_pkg::SYNC_TS1_DATA, 1'b0, 1'b1, 4'h5,
                                      tbss_pkg::DT_CSBK));
        burst_queue.push_back(mk_data(tbss_pkg::SYNC_TS2_DATA, 1'b0, 1'b1, 4'hA,
                                      tbss_pkg::DT_IDLE_ALT));
        burst_queue.push_back(mk_data(tbss_pkg::SYNC_BS_DATA, 1'b1, 1'b1, 4'h3, 4'hF));
        // simplex superframe with full embedded lc, then past position f
        burst_queue.push_back(mk(tbss_pkg::SYNC_MS_VOICE, 1'b0, 1'b0, 1'b0, 1'b1,
                                 tbss_pkg::LCSS_SINGLE, 32'h0));
        burst_queue.push_back(mk(tbss_pkg::SYNC_NONE, 1'b0, 1'b0, 1'b0, 1'b1,
                                 tbss_pkg::LCSS_FIRST, 32'hFFFF_FFFF));
        burst_queue.push_back(mk(tbss_pkg::SYNC_NONE, 1'b0, 1'b0, 1'b0, 1'b1,
                                 tbss_pkg::LCSS_CONT, 32'h0000_0000));
        burst_queue.push_back(mk(tbss_pkg::SYNC_NONE, 1'b0, 1'b0, 1'b0, 1'b1,
                                 tbss_pkg::LCSS_CONT, 32'hA5A5_5A5A));
        burst_queue.push_back(mk(tbss_pkg::SYNC_NONE, 1'b0, 1'b0, 1'b0, 1'b1,
                                 tbss_pkg::LCSS_LAST, 32'h8000_0001));
        burst_queue.push_back(mk(tbss_pkg::SYNC_NONE, 1'b0, 1'b0, 1'b0, 1'b1,
                                 tbss_pkg::LCSS_SINGLE, 32'h0));
        burst_queue.push_back(mk(tbss_pkg::SYNC_NONE, 1'b0, 1'b0, 1'b0, 1'b1,
                                 tbss_pkg::LCSS_FIRST, 32'hFFFF_FFFF));
        // cleared proven flag, stray continuation, run of failed embedded words
        b = mk(tbss_pkg::SYNC_MS_VOICE, 1'b0, 1'b0, 1'b0, 1'b1, tbss_pkg::LCSS_SINGLE, 32'h0);
        b.clr = 1'b1;
        burst_queue.push_back(b);
        burst_queue.push_back(mk(tbss_pkg::SYNC_NONE, 1'b0, 1'b0, 1'b0, 1'b1,
                                 tbss_pkg::LCSS_CONT, 32'h1234_5678));
        for (int i = 0; i < 4; i++)
            burst_queue.push_back(mk(tbss_pkg::SYNC_NONE, 1'b0, 1'b0, 1'b0, 1'b0,
                                     tbss_pkg::LCSS_FIRST, $urandom));
        // unknown sync kinds
        burst_queue.push_back(mk(4'd12, 1'b0, 1'b1, 1'b1, 1'b1, tbss_pkg::LCSS_FIRST,
                                 $urandom));
        burst_queue.push_back(mk(4'd15, 1'b1, 1'b1, 1'b0, 1'b1, tbss_pkg::LCSS_LAST,
                                 $urandom));

        while (burst_queue.size() < 1030)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gen_superframe(0, 6);
                4: gen_superframe(1, 6);
                5: gen_superframe(2, 6);
                6: gen_superframe($urandom_range(0, 2), 50);
                7: gen_data_run();
                default:
                begin
                    repeat ($urandom_range(1, 3))
                        burst_queue.push_back(noise_burst());
                end
            endcase
        end
        burst_queue[26].pause_before = 1'b1;
        burst_queue[600].pause_before = 1'b1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (burst_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tbss_pkg.sv
rtl/tdma_burst_slot_sequencer.sv
tb/sv/tb.sv
